// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset, sampled on clk
`define BFPA_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define BFPA_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/bfpa_pkg.sv
// ----------------------------------------------------------------------------
// bfpa_pkg
// types and constants of the best-fit partition allocator
// ----------------------------------------------------------------------------
package bfpa_pkg;

  localparam int PART_COUNT = 16;
  localparam int SIZE_BITS  = 16;
  localparam int IDX_W      = (PART_COUNT > 1) ? $clog2(PART_COUNT) : 1;

  // fixed field widths
  localparam int OP_W    = 2;
  localparam int BIDX_W  = 4;
  localparam int FSIZE_W = 16;
  localparam int ST_W    = 2;
  localparam int CFG_W   = 5;

  localparam logic [CFG_W-1:0] ACTIVE_RESET = 5'd16;

  typedef enum logic [OP_W-1:0] {
    OP_SET   = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_DONE    = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_NOTBUSY = 2'd2,
    ST_RANGE   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_EMIT
  } state_t;

  // best candidate handed down the cell chain
  typedef struct packed {
    logic                 found;
    logic [IDX_W-1:0]     idx;
    logic [SIZE_BITS-1:0] left;
  } cand_t;

  // command broadcast to every cell
  typedef struct packed {
    logic                 wr_size;
    logic                 set_busy;
    logic                 clr_busy;
    logic [IDX_W-1:0]     target;
    logic [SIZE_BITS-1:0] size;
    logic [SIZE_BITS-1:0] req;
  } cell_cmd_t;

endpackage

// File: design/bfpa_if.sv
// ----------------------------------------------------------------------------
// bfpa_in_if / bfpa_out_if
// valid/ready channels for request items and result items
// ----------------------------------------------------------------------------
interface bfpa_in_if;
  logic                               valid;
  logic                               ready;
  logic [bfpa_pkg::OP_W-1:0]          op;
  logic [bfpa_pkg::BIDX_W-1:0]        block_index;
  logic [bfpa_pkg::FSIZE_W-1:0]       block_size;
  logic [bfpa_pkg::FSIZE_W-1:0]       request_size;

  modport source (output valid, op, block_index, block_size, request_size, input ready);
  modport sink   (input valid, op, block_index, block_size, request_size, output ready);
endinterface

interface bfpa_out_if;
  logic                               valid;
  logic                               ready;
  logic [bfpa_pkg::ST_W-1:0]          status;
  logic [bfpa_pkg::BIDX_W-1:0]        granted_block;
  logic [bfpa_pkg::FSIZE_W-1:0]       leftover;

  modport source (output valid, status, granted_block, leftover, input ready);
  modport sink   (input valid, status, granted_block, leftover, output ready);
endinterface

// File: design/bfpa_cell.sv
// ----------------------------------------------------------------------------
// bfpa_cell
// one partition: size and busy flag, plus one stage of the best-fit chain
// ----------------------------------------------------------------------------
module bfpa_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [bfpa_pkg::IDX_W-1:0]   cell_idx,
  input  logic                         active,
  input  bfpa_pkg::cell_cmd_t          cmd,
  input  bfpa_pkg::cand_t              prev,
  output bfpa_pkg::cand_t              next,
  output logic                         busy
);

  logic [bfpa_pkg::SIZE_BITS-1:0] size_r, size_nxt;
  logic                           busy_r, busy_nxt;
  bfpa_pkg::cand_t                cand_r, cand_nxt;

  logic                           hit;
  logic                           fits;
  logic                           take;
  logic [bfpa_pkg::SIZE_BITS-1:0] left;

  always_comb begin
    hit      = (cmd.target == cell_idx);
    size_nxt = size_r;
    busy_nxt = busy_r;
    if (hit && cmd.wr_size) begin
      size_nxt = cmd.size;
      busy_nxt = 1'b0;
    end else if (hit && cmd.clr_busy) begin
      busy_nxt = 1'b0;
    end else if (hit && cmd.set_busy) begin
      busy_nxt = 1'b1;
    end

    // compare own partition against the best seen upstream; ties keep upstream
    left     = size_r - cmd.req;
    fits     = active && !busy_r && (size_r >= cmd.req);
    take     = fits && (!prev.found || (left < prev.left));
    cand_nxt = prev;
    if (take) begin
      cand_nxt.found = 1'b1;
      cand_nxt.idx   = cell_idx;
      cand_nxt.left  = left;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= '0;
      busy_r <= 1'b0;
      cand_r <= '0;
    end else begin
      size_r <= size_nxt;
      busy_r <= busy_nxt;
      cand_r <= cand_nxt;
    end
  end

  assign next = cand_r;
  assign busy = busy_r;

endmodule

// File: design/best_fit_partition_allocator_core.sv
// ----------------------------------------------------------------------------
// best_fit_partition_allocator_core
// fixed-partition table with best-fit allocate, set-size and free items
// ----------------------------------------------------------------------------
// channel   dir  handshake          payload
// in_ch     in   valid/ready        op, block_index, block_size, request_size
// out_ch    out  valid/ready        status, granted_block, leftover
// cfg       in   cfg_we, no ready   cfg_wdata = active_blocks
//
// one item at a time: set-size, free and unused codes pass the exec and emit states;
// allocate adds the scan state between them
// the allocate scan lasts while the candidate walks the chain of cells,
// one cell per cycle
// a result waits in the output register; a new item is taken meanwhile,
// and its own result waits for that register to drain
// synchronous active-low reset: all partitions free with size zero,
// active_blocks = 16
// ----------------------------------------------------------------------------
module best_fit_partition_allocator_core (
  input  logic                          clk,
  input  logic                          rst_n,
  bfpa_in_if.sink                       in_ch,
  bfpa_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [bfpa_pkg::CFG_W-1:0]    cfg_wdata
);

  localparam int N  = bfpa_pkg::PART_COUNT;
  localparam int IW = bfpa_pkg::IDX_W;
  localparam int SB = bfpa_pkg::SIZE_BITS;

  bfpa_pkg::state_t               state_r, state_nxt;
  logic [bfpa_pkg::OP_W-1:0]      op_r;
  logic [bfpa_pkg::BIDX_W-1:0]    idx_r;
  logic [SB-1:0]                  bsize_r;
  logic [SB-1:0]                  req_r;
  logic [bfpa_pkg::CFG_W-1:0]     act_r;
  logic [IW-1:0]                  scan_cnt_r, scan_cnt_nxt;

  logic                           out_valid_r, out_valid_nxt;
  logic [bfpa_pkg::ST_W-1:0]      status_r, status_nxt;
  logic [bfpa_pkg::BIDX_W-1:0]    granted_r, granted_nxt;
  logic [bfpa_pkg::FSIZE_W-1:0]   leftover_r, leftover_nxt;

  logic                           in_fire;
  logic                           emit_fire;
  logic                           in_table;   // index inside the partition table
  logic                           in_active;  // index inside the active partitions
  logic [IW-1:0]                  tgt_idx;

  bfpa_pkg::cell_cmd_t            cmd;
  bfpa_pkg::cand_t                chain [N+1];
  logic [N-1:0]                   busy_vec;

  assign in_ch.ready = (state_r == bfpa_pkg::S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // result register frees up when it is empty or being taken
  assign emit_fire = (state_r == bfpa_pkg::S_EMIT) && (!out_valid_r || out_ch.ready);

  assign in_table  = (32'(idx_r) < N);
  assign in_active = in_table && (32'(idx_r) < 32'(act_r));
  assign tgt_idx   = IW'(idx_r);

  // ---------------------------------------------------------------------------
  // cell chain: chain[0] is "nothing found", last register holds the winner
  // ---------------------------------------------------------------------------
  assign chain[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    bfpa_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IW'(i)),
      .active   (32'(i) < 32'(act_r)),
      .cmd      (cmd),
      .prev     (chain[i]),
      .next     (chain[i+1]),
      .busy     (busy_vec[i])
    );
  end

  // ---------------------------------------------------------------------------
  // sequencer and result build
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    scan_cnt_nxt  = scan_cnt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    status_nxt    = status_r;
    granted_nxt   = granted_r;
    leftover_nxt  = leftover_r;

    cmd          = '0;
    cmd.req      = req_r;
    cmd.size     = bsize_r;
    cmd.target   = tgt_idx;

    case (state_r)
      bfpa_pkg::S_IDLE: begin
        if (in_fire) begin
          state_nxt = bfpa_pkg::S_EXEC;
        end
      end
      bfpa_pkg::S_EXEC: begin
        scan_cnt_nxt = '0;
        if (op_r == bfpa_pkg::OP_ALLOC) begin
          state_nxt = bfpa_pkg::S_SCAN;
        end else begin
          state_nxt = bfpa_pkg::S_EMIT;
        end
      end
      bfpa_pkg::S_SCAN: begin
        // wait while the candidate walks the chain of cells to its end
        scan_cnt_nxt = scan_cnt_r + 1'b1;
        if (scan_cnt_r == IW'(N - 1)) begin
          state_nxt = bfpa_pkg::S_EMIT;
        end
      end
      bfpa_pkg::S_EMIT: begin
        if (emit_fire) begin
          state_nxt     = bfpa_pkg::S_IDLE;
          out_valid_nxt = 1'b1;
          status_nxt    = bfpa_pkg::ST_DONE;
          granted_nxt   = '0;
          leftover_nxt  = '0;
          case (op_r)
            bfpa_pkg::OP_SET: begin
              if (!in_table) begin
                status_nxt = bfpa_pkg::ST_RANGE;
              end else begin
                cmd.wr_size = 1'b1;
              end
            end
            bfpa_pkg::OP_ALLOC: begin
              if (chain[N].found) begin
                cmd.set_busy = 1'b1;
                cmd.target   = chain[N].idx;
                granted_nxt  = bfpa_pkg::BIDX_W'(chain[N].idx);
                leftover_nxt = bfpa_pkg::FSIZE_W'(chain[N].left);
              end else begin
                status_nxt = bfpa_pkg::ST_NOFIT;
              end
            end
            bfpa_pkg::OP_FREE: begin
              if (!in_active) begin
                status_nxt = bfpa_pkg::ST_RANGE;
              end else if (!busy_vec[tgt_idx]) begin
                status_nxt = bfpa_pkg::ST_NOTBUSY;
              end else begin
                cmd.clr_busy = 1'b1;
              end
            end
            default: begin
              // unused op code: plain done, nothing changes
              status_nxt = bfpa_pkg::ST_DONE;
            end
          endcase
        end
      end
      default: begin
        state_nxt = bfpa_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bfpa_pkg::S_IDLE;
      scan_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      act_r       <= bfpa_pkg::ACTIVE_RESET;
    end else begin
      state_r     <= state_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        act_r <= cfg_wdata;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r    <= in_ch.op;
      idx_r   <= in_ch.block_index;
      bsize_r <= SB'(in_ch.block_size);
      req_r   <= SB'(in_ch.request_size);
    end
    status_r   <= status_nxt;
    granted_r  <= granted_nxt;
    leftover_r <= leftover_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = status_r;
  assign out_ch.granted_block = granted_r;
  assign out_ch.leftover      = leftover_r;

endmodule

// File: design/bfpa_checker.sv
// ----------------------------------------------------------------------------
// bfpa_checker
// port-level checks on the best-fit partition allocator
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bfpa_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [bfpa_pkg::ST_W-1:0]        status,
  input logic [bfpa_pkg::BIDX_W-1:0]      granted_block,
  input logic [bfpa_pkg::FSIZE_W-1:0]     leftover
);

  localparam int OUT_W = bfpa_pkg::ST_W + bfpa_pkg::BIDX_W + bfpa_pkg::FSIZE_W;

  logic             in_acc;
  logic             stall;
  logic             failed;
  logic             fields_zero;
  logic [OUT_W-1:0] out_word;

  assign in_acc      = in_valid && in_ready;
  assign stall       = out_valid && !out_ready;
  assign failed      = out_valid && (status != bfpa_pkg::ST_DONE);
  assign fields_zero = (granted_block == '0) && (leftover == '0);
  assign out_word    = {status, granted_block, leftover};

  // reset empties the result register
  `BFPA_CHECK_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

  // one item in flight: taking an item closes the input
  `BFPA_CHECK(a_one_in_flight, in_acc |=> !in_ready, "second item taken while busy")

  // only a granted allocate carries an index or leftover
  `BFPA_CHECK(a_zero_fields, failed |-> fields_zero, "nonzero fields on failed item")

  // stalled result holds
  `BFPA_CHECK(a_out_hold, stall |=> (out_valid && $stable(out_word)), "stalled result changed")

endmodule

bind best_fit_partition_allocator_core bfpa_checker u_bfpa_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .status        (out_ch.status),
  .granted_block (out_ch.granted_block),
  .leftover      (out_ch.leftover)
);

// File: verif/tb_best_fit_partition_allocator_core.sv
// ----------------------------------------------------------------------------
// tb_best_fit_partition_allocator_core
// self-checking bench for the best-fit partition allocator
// ----------------------------------------------------------------------------
// a behavioral copy of the partition table predicts the result of every
// accepted request item; the results are checked in order, field by field
// directed tests cover reset state, best-fit choice with ties, the active
// count limits and output backpressure; random traffic then runs under
// several active_blocks settings, with bursty input and a stalling receiver
// ----------------------------------------------------------------------------
module tb_best_fit_partition_allocator_core;
  timeunit 1ns;
  timeprecision 1ps;

  // op code the block ignores
  localparam logic [bfpa_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int CLK_HALF = 4;
  localparam int ITEMS_PER_PHASE = 140;
  localparam int SETTLE_CYCLES = 25;

  typedef struct packed {
    bfpa_pkg::status_t                 status;
    logic [bfpa_pkg::BIDX_W-1:0]       granted_block;
    logic [bfpa_pkg::FSIZE_W-1:0]      leftover;
  } grant_t;

  // receiver behaviors between long hold-offs
  typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       cfg_we;
  logic [bfpa_pkg::CFG_W-1:0] cfg_wdata;

  bfpa_in_if  in_ch ();
  bfpa_out_if out_ch ();

  best_fit_partition_allocator_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #CLK_HALF clk = ~clk;

  // shadow copy of the partition table and the active count
  logic [bfpa_pkg::SIZE_BITS-1:0] part_size [bfpa_pkg::PART_COUNT];
  logic                           part_busy [bfpa_pkg::PART_COUNT];
  logic [bfpa_pkg::CFG_W-1:0]     active_setting;

  // results still owed by the block, oldest first
  grant_t pending_grants [$];

  int mismatch_count = 0;
  int burst_left = 0;      // items left in the current sender burst
  bit offering = 1'b0;     // in_ch.valid is being held high
  int hold_request = 0;    // long receiver hold-off asked by a test

  function automatic void reset_model();
    for (int i = 0; i < bfpa_pkg::PART_COUNT; i++) begin
      part_size[i] = '0;
      part_busy[i] = 1'b0;
    end
    active_setting = bfpa_pkg::ACTIVE_RESET;
  endfunction

  // updates the shadow table and returns the result the block must give
  function automatic grant_t predict_grant(input logic [bfpa_pkg::OP_W-1:0] op,
                                           input logic [bfpa_pkg::BIDX_W-1:0] idx,
                                           input logic [bfpa_pkg::FSIZE_W-1:0] bsize,
                                           input logic [bfpa_pkg::FSIZE_W-1:0] req);
    grant_t                         g;
    int                             n;
    bit                             found;
    int                             best;
    logic [bfpa_pkg::SIZE_BITS-1:0] best_left;
    logic [bfpa_pkg::SIZE_BITS-1:0] want;
    logic [bfpa_pkg::SIZE_BITS-1:0] room;
    g = '{status: bfpa_pkg::ST_DONE, granted_block: '0, leftover: '0};
    // an active count above the table size acts as the table size
    n = (int'(active_setting) > bfpa_pkg::PART_COUNT) ? bfpa_pkg::PART_COUNT
                                                      : int'(active_setting);
    want = bfpa_pkg::SIZE_BITS'(req);
    found = 1'b0;
    best = 0;
    best_left = '0;
    case (op)
      bfpa_pkg::OP_SET: begin
        if (int'(idx) >= bfpa_pkg::PART_COUNT) begin
          g.status = bfpa_pkg::ST_RANGE;
        end else begin
          // writes even beyond the active count, and frees the partition
          part_size[idx] = bfpa_pkg::SIZE_BITS'(bsize);
          part_busy[idx] = 1'b0;
        end
      end
      bfpa_pkg::OP_ALLOC: begin
        // smallest leftover wins, strict compare keeps the lowest index on ties
        for (int i = 0; i < n; i++) begin
          if (!part_busy[i] && part_size[i] >= want) begin
            room = part_size[i] - want;
            if (!found || room < best_left) begin
              found = 1'b1;
              best = i;
              best_left = room;
            end
          end
        end
        if (found) begin
          part_busy[best] = 1'b1;
          g.granted_block = bfpa_pkg::BIDX_W'(best);
          g.leftover = bfpa_pkg::FSIZE_W'(best_left);
        end else begin
          g.status = bfpa_pkg::ST_NOFIT;
        end
      end
      bfpa_pkg::OP_FREE: begin
        if (int'(idx) >= n) begin
          g.status = bfpa_pkg::ST_RANGE;
        end else if (!part_busy[idx]) begin
          g.status = bfpa_pkg::ST_NOTBUSY;
        end else begin
          part_busy[idx] = 1'b0;
        end
      end
      default: begin
        // unused code: no state change, plain done
      end
    endcase
    return g;
  endfunction

  // sizes biased toward the extremes and a coarse grid so that ties happen
  function automatic logic [bfpa_pkg::FSIZE_W-1:0] random_size();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3, 4, 5: return bfpa_pkg::FSIZE_W'($urandom_range(0, 15) * 16);
      6, 7: return bfpa_pkg::FSIZE_W'($urandom_range(0, 600));
      default: return bfpa_pkg::FSIZE_W'($urandom);
    endcase
  endfunction

  // offers one request item and waits for it to be taken; the sender runs
  // in bursts of random length with random gaps in between
  task automatic send_request(input logic [bfpa_pkg::OP_W-1:0] op,
                              input logic [bfpa_pkg::BIDX_W-1:0] idx,
                              input logic [bfpa_pkg::FSIZE_W-1:0] bsize,
                              input logic [bfpa_pkg::FSIZE_W-1:0] req);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        if (offering) begin
          in_ch.valid <= 1'b0;
          offering = 1'b0;
        end
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid        <= 1'b1;
    in_ch.op           <= op;
    in_ch.block_index  <= idx;
    in_ch.block_size   <= bsize;
    in_ch.request_size <= req;
    offering = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    // accepted at this edge; items are taken in order so predict now
    pending_grants.push_back(predict_grant(op, idx, bsize, req));
    burst_left--;
  endtask

  // stops offering and waits until every owed result has come back
  task automatic drain_results();
    if (offering) begin
      in_ch.valid <= 1'b0;
      offering = 1'b0;
    end
    while (pending_grants.size() != 0) @(posedge clk);
    // every item gives a result, so once none is owed the block is idle
    repeat (4) @(posedge clk);
  endtask

  // only called with the block idle
  task automatic write_active(input logic [bfpa_pkg::CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    active_setting = value;
  endtask

  task automatic send_random_item();
    int                          pick;
    logic [bfpa_pkg::BIDX_W-1:0] idx;
    int                          busy_list [$];
    pick = $urandom_range(0, 99);
    idx = bfpa_pkg::BIDX_W'($urandom_range(0, bfpa_pkg::PART_COUNT - 1));
    if (pick < 25) begin
      send_request(bfpa_pkg::OP_SET, idx, random_size(), bfpa_pkg::FSIZE_W'($urandom));
    end else if (pick < 65) begin
      send_request(bfpa_pkg::OP_ALLOC, idx, bfpa_pkg::FSIZE_W'($urandom), random_size());
    end else if (pick < 95) begin
      // mostly free a partition that is really busy, otherwise any index
      for (int i = 0; i < bfpa_pkg::PART_COUNT; i++)
        if (part_busy[i]) busy_list.push_back(i);
      if (busy_list.size() != 0 && $urandom_range(0, 3) != 0)
        idx = bfpa_pkg::BIDX_W'(busy_list[$urandom_range(0, busy_list.size() - 1)]);
      send_request(bfpa_pkg::OP_FREE, idx, bfpa_pkg::FSIZE_W'($urandom),
                   bfpa_pkg::FSIZE_W'($urandom));
    end else begin
      send_request(OP_UNUSED, idx, bfpa_pkg::FSIZE_W'($urandom),
                   bfpa_pkg::FSIZE_W'($urandom));
    end
  endtask

  // table straight out of reset: every partition free with size zero
  task automatic test_reset_state();
    send_request(bfpa_pkg::OP_ALLOC, 4'd0, '0, '0);    // zero request fits an empty partition
    send_request(bfpa_pkg::OP_ALLOC, 4'd0, '0, 16'd1); // nothing fits
    send_request(bfpa_pkg::OP_FREE, 4'd15, '0, '0);    // last index, not busy
    send_request(bfpa_pkg::OP_FREE, 4'd0, '0, '0);     // frees the grant above
    send_request(bfpa_pkg::OP_FREE, 4'd0, '0, '0);     // already free
  endtask

  // best fit with ties, exact fits, largest sizes and the unused code
  task automatic test_best_fit_choice();
    send_request(bfpa_pkg::OP_SET, 4'd3, 16'd100, '0);
    send_request(bfpa_pkg::OP_SET, 4'd5, 16'd50, '0);
    send_request(bfpa_pkg::OP_SET, 4'd7, 16'd50, '0);
    send_request(bfpa_pkg::OP_SET, 4'd9, 16'd49, '0);
    send_request(bfpa_pkg::OP_SET, 4'd15, '1, '0);
    send_request(bfpa_pkg::OP_ALLOC, '1, '1, 16'd50);  // tie between 5 and 7, lower wins
    send_request(bfpa_pkg::OP_ALLOC, '0, '0, 16'd50);  // now 7
    send_request(bfpa_pkg::OP_ALLOC, '0, '0, 16'd50);  // 3 beats 15, leftover 50
    send_request(bfpa_pkg::OP_ALLOC, '0, '0, '1);      // full-size request
    send_request(bfpa_pkg::OP_ALLOC, '0, '0, '1);      // largest partition taken
    send_request(bfpa_pkg::OP_ALLOC, '0, '0, '0);      // zero request, smallest free
    send_request(bfpa_pkg::OP_SET, 4'd15, '1, '0);     // rewriting a busy partition frees it
    send_request(OP_UNUSED, '1, '1, '1);
    send_request(bfpa_pkg::OP_FREE, 4'd5, '0, '0);
    send_request(bfpa_pkg::OP_FREE, 4'd5, '0, '0);     // second free is refused
  endtask

  // zero active partitions, and a count beyond the table
  task automatic test_active_count_limits();
    drain_results();
    write_active(5'd0);
    send_request(bfpa_pkg::OP_ALLOC, '0, '0, '0);      // nothing active, no fit
    send_request(bfpa_pkg::OP_FREE, '0, '0, '0);       // every index out of range
    drain_results();
    write_active(5'd31);
    send_request(bfpa_pkg::OP_ALLOC, '0, '0, '1);      // top partition still reachable
    send_request(bfpa_pkg::OP_FREE, 4'd15, '0, '0);
    drain_results();
  endtask

  // receiver holds off long enough for the block to fill and stall its input
  task automatic test_output_backpressure();
    hold_request = 300;
    burst_left = 16;
    repeat (16) send_random_item();
    drain_results();
  endtask

  // random traffic under a series of active counts
  task automatic test_random_traffic();
    logic [bfpa_pkg::CFG_W-1:0] settings [6];
    logic [bfpa_pkg::CFG_W-1:0] setting;
    settings = '{5'd16, 5'd3, 5'd1, 5'd0, 5'd31, 5'd17};
    for (int p = 0; p < 8; p++) begin
      drain_results();
      setting = (p < 6) ? settings[p] : bfpa_pkg::CFG_W'($urandom_range(0, 31));
      write_active(setting);
      repeat (ITEMS_PER_PHASE) send_random_item();
    end
  endtask

  // result checker: every taken result against the oldest expectation
  always @(posedge clk) begin : check_results
    grant_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_grants.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with no item owed: status %0d block %0d leftover %0d",
                 $time, out_ch.status, out_ch.granted_block, out_ch.leftover);
      end else begin
        want = pending_grants.pop_front();
        if (out_ch.status !== want.status) begin
          mismatch_count++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_ch.status);
        end
        if (out_ch.granted_block !== want.granted_block) begin
          mismatch_count++;
          $display("%0t: granted_block expected %0d actual %0d",
                   $time, want.granted_block, out_ch.granted_block);
        end
        if (out_ch.leftover !== want.leftover) begin
          mismatch_count++;
          $display("%0t: leftover expected %0d actual %0d",
                   $time, want.leftover, out_ch.leftover);
        end
      end
    end
  end

  // receiver: random stall patterns, plus long hold-offs on request
  initial begin : result_receiver
    int       hold_left;
    int       pattern_left;
    rx_mode_t pattern_mode;
    hold_left = 0;
    pattern_left = 0;
    pattern_mode = RX_ALWAYS;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (pattern_left == 0) begin
          pattern_mode = rx_mode_t'($urandom_range(0, 3));
          pattern_left = $urandom_range(4, 60);
        end
        pattern_left--;
        case (pattern_mode)
          RX_ALWAYS: out_ch.ready <= 1'b1;
          RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default:   out_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // main sequence
  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.op = '0;
    in_ch.block_index = '0;
    in_ch.block_size = '0;
    in_ch.request_size = '0;
    reset_model();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_best_fit_choice();
    test_active_count_limits();
    test_output_backpressure();
    test_random_traffic();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_grants.size() == 0) begin
      $display("[best_fit_partition_allocator_core] OK");
    end else begin
      $display("[best_fit_partition_allocator_core] ERROR");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("[best_fit_partition_allocator_core] ERROR");
    $finish;
  end

endmodule

// File: sim.f
+incdir+design
design/bfpa_pkg.sv
design/bfpa_if.sv
design/bfpa_cell.sv
design/best_fit_partition_allocator_core.sv
design/bfpa_checker.sv
verif/tb_best_fit_partition_allocator_core.sv
